/* sv/key_matrix_debounce_top_macros.svh */
// Assertion macros shared by the key matrix debounce RTL.
`ifndef KEY_MATRIX_DEBOUNCE_TOP_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define KMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge out of reset.
`define KMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/kmd_pkg.sv */
// Types and constants of the key matrix debounce block.
package kmd_pkg;

    localparam int ROW_W        = 2;
    localparam int COL_W        = 2;
    localparam int TIME_W       = 32;
    localparam int DEB_W        = 16;
    localparam int PKEY_W       = 4;
    localparam int KEY_LIN_W    = 8;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 8;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

    // Per-key state record held in the state memory
    typedef struct packed {
        logic              last_raw;
        logic [TIME_W-1:0] change_time;
        logic              stable_level;
    } kmd_rec_t;

endpackage

/* sv/kmd_state_ram.sv */
// Per-key state memory: one write and one registered read port, valid bits per entry.
module kmd_state_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output kmd_pkg::kmd_rec_t rd_rec,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  kmd_pkg::kmd_rec_t wr_rec
);
    import kmd_pkg::*;

    kmd_rec_t           mem [DEPTH];
    kmd_rec_t           rd_q_reg;
    logic               rd_vld_reg;
    logic [DEPTH-1:0]   vld_reg;

    // Write port and registered read of the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_rec;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Track which entries hold written data; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Mask entries that were never written since reset
    assign rd_rec = rd_vld_reg ? rd_q_reg : '0;

endmodule

/* sv/key_matrix_debounce_top.sv */
// Top level of the per-key debouncer for a scanned key matrix.
//
// Input stream (s_axis_*): one word per scanned key reading, with row, column,
// raw level and a millisecond time stamp. Output stream (m_axis_*): one word per
// reading with the press pulse request, the key index and the debounced level.
// Configuration: cfg_wr_en / cfg_wr_data write the debounce time in ms (reset 50).
//
// An accepted word is registered in the compute stage, then in the output register. One
// word is taken per cycle unless the output stalls; state memory is read on accept and
// written back as the word leaves the compute stage; a one-entry bypass register serves
// the next reading of that key. Out-of-range readings leave state untouched and give zeros.
//
// Reset sets the debounce time back to 50 ms and clears the per-entry valid bits of the
// state memory, so every key starts released with a change time of zero; no clearing
// pass is run.
// When the receiver stalls, the output word holds, one more word waits in the compute
// stage, and s_axis_tready drops only when both are full.
`include "key_matrix_debounce_top_macros.svh"

module key_matrix_debounce_top #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Debounce time write port
    input  logic                           cfg_wr_en,
    input  logic [kmd_pkg::DEB_W-1:0]      cfg_wr_data,
    // Input words
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [1:0] key_row, [3:2] key_col, [4] raw_level, [36:5] now_ms, [39:37] zero
    input  logic [kmd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Output words
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] press_fire, [4:1] pulse_key, [5] debounced_level, [7:6] zero
    output logic [kmd_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import kmd_pkg::*;

    localparam int NKEYS = ROWS * COLS;
    localparam int AW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;

    // Input word fields
    logic [ROW_W-1:0]     in_row;
    logic [COL_W-1:0]     in_col;
    logic                 in_raw;
    logic [TIME_W-1:0]    in_now;
    logic [KEY_LIN_W-1:0] in_key;
    logic                 in_range;
    logic                 s_fire;

    // Compute stage
    logic                 s1_vld_reg, s1_vld_next;
    logic [KEY_LIN_W-1:0] s1_key_reg;
    logic                 s1_range_reg;
    logic                 s1_raw_reg;
    logic [TIME_W-1:0]    s1_now_reg;
    logic                 s1_adv;

    // Bypass of the last write
    logic                 fwd_vld_reg;
    logic [AW-1:0]        fwd_addr_reg;
    kmd_rec_t             fwd_rec_reg;

    // Output register
    logic                 out_vld_reg, out_vld_next;
    logic                 out_fire_reg;
    logic [PKEY_W-1:0]    out_key_reg;
    logic                 out_level_reg;

    logic [DEB_W-1:0]     deb_reg;

    kmd_rec_t             rd_rec;
    kmd_rec_t             cur_rec;
    kmd_rec_t             new_rec;
    logic                 fwd_hit;
    logic                 raw_chg;
    logic [TIME_W-1:0]    elapsed;
    logic                 take;
    logic                 wr_en;
    logic [AW-1:0]        s1_addr;

    // Unpack the input word and form the linear key index
    assign in_row   = s_axis_tdata[1:0];
    assign in_col   = s_axis_tdata[3:2];
    assign in_raw   = s_axis_tdata[4];
    assign in_now   = s_axis_tdata[36:5];
    assign in_key   = KEY_LIN_W'(in_row) * KEY_LIN_W'(COLS) + KEY_LIN_W'(in_col);
    assign in_range = (5'(in_row) < 5'(ROWS)) && (5'(in_col) < 5'(COLS));

    // Handshake: compute stage advances when the output register is free or taken
    assign s1_adv        = s1_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !s1_vld_reg || s1_adv;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign s1_vld_next  = s_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_reg);
    assign out_vld_next = s1_adv ? 1'b1 : ((m_axis_tready) ? 1'b0 : out_vld_reg);

    kmd_state_ram #(
        .DEPTH (NKEYS),
        .AW    (AW)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_fire),
        .rd_addr (in_key[AW-1:0]),
        .rd_rec  (rd_rec),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_rec  (new_rec)
    );

    // Pick the freshest record: bypass the write that landed with this read
    assign s1_addr = s1_key_reg[AW-1:0];
    assign fwd_hit = fwd_vld_reg && (fwd_addr_reg == s1_addr);
    assign cur_rec = fwd_hit ? fwd_rec_reg : rd_rec;

    // Debounce update of the record
    assign raw_chg = s1_raw_reg != cur_rec.last_raw;
    assign elapsed = s1_now_reg - cur_rec.change_time;
    assign take    = !raw_chg && (elapsed > TIME_W'(deb_reg))
                     && (s1_raw_reg != cur_rec.stable_level);

    always_comb
    begin
        new_rec.last_raw     = s1_raw_reg;
        new_rec.change_time  = raw_chg ? s1_now_reg : cur_rec.change_time;
        new_rec.stable_level = take ? s1_raw_reg : cur_rec.stable_level;
    end

    assign wr_en = s1_adv && s1_range_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            fwd_vld_reg <= 1'b0;
            deb_reg     <= DEBOUNCE_RESET;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            if (wr_en)
            begin
                fwd_vld_reg <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                deb_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Capture the accepted reading
        if (s_fire)
        begin
            s1_key_reg   <= in_key;
            s1_range_reg <= in_range;
            s1_raw_reg   <= in_raw;
            s1_now_reg   <= in_now;
        end
        // Hold the last written record for the bypass
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_rec_reg  <= new_rec;
        end
        // Load the output word
        if (s1_adv)
        begin
            out_fire_reg  <= s1_range_reg && take && s1_raw_reg;
            out_key_reg   <= s1_range_reg ? s1_key_reg[PKEY_W-1:0] : '0;
            out_level_reg <= s1_range_reg && new_rec.stable_level;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_level_reg, out_key_reg, out_fire_reg};

    // A press request always comes with a pressed debounced level
    `KMD_ASSERT_NOW(a_fire_level, out_vld_reg && out_fire_reg, out_level_reg,
        "press request without pressed level")
    // State is written back only by an advancing in-range reading
    `KMD_ASSERT_NOW(a_wr_src, wr_en, s1_vld_reg && s1_range_reg && out_vld_next,
        "state write without an advancing reading")
    // Input is refused only while both stages are full and the output is stalled
    `KMD_ASSERT_NOW(a_ready, !s_axis_tready, s1_vld_reg && out_vld_reg && !m_axis_tready,
        "input refused with room in the pipeline")
    // An accepted reading is in the compute stage in the next cycle
    `KMD_ASSERT_NEXT(a_load, s_fire, s1_vld_reg, "accepted reading lost")

endmodule

/* tb/key_matrix_debounce_top_tb.sv */
// Self-checking testbench of the key matrix debouncer: stream stimulus, scoreboard, watchdog.
`timescale 1ns / 100ps

typedef struct packed {
    logic [2:0]                     pad;
    logic [kmd_pkg::TIME_W-1:0]     now_ms;
    logic                           raw_level;
    logic [kmd_pkg::COL_W-1:0]      key_col;
    logic [kmd_pkg::ROW_W-1:0]      key_row;
} key_reading_t;

typedef struct packed {
    logic [1:0]                     pad;
    logic                           debounced_level;
    logic [kmd_pkg::PKEY_W-1:0]     pulse_key;
    logic                           press_fire;
} key_event_t;

// Predict the debouncer per key and match the output words in order
class debounce_scoreboard;
    localparam int KEY_ROWS  = 4;
    localparam int KEY_COLS  = 4;
    localparam int KEY_COUNT = KEY_ROWS * KEY_COLS;

    logic                       last_raw [KEY_COUNT];
    logic [kmd_pkg::TIME_W-1:0] change_ms [KEY_COUNT];
    logic                       settled [KEY_COUNT];
    logic [kmd_pkg::DEB_W-1:0]  debounce;
    key_event_t                 expected_words [$];
    int                         failures;
    int                         presses_seen;

    function new();
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            last_raw[k]  = 1'b0;
            change_ms[k] = '0;
            settled[k]   = 1'b0;
        end
        debounce     = kmd_pkg::DEBOUNCE_RESET;
        failures     = 0;
        presses_seen = 0;
    endfunction

    function void set_debounce(logic [kmd_pkg::DEB_W-1:0] value);
        debounce = value;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    // Advance the state of the scanned key and queue the word it should give
    function void note_reading(key_reading_t rd);
        key_event_t                 ev;
        int                         key;
        logic [kmd_pkg::TIME_W-1:0] elapsed;
        ev = '0;
        if (int'(rd.key_row) < KEY_ROWS && int'(rd.key_col) < KEY_COLS)
        begin
            key = int'(rd.key_row) * KEY_COLS + int'(rd.key_col);
            if (rd.raw_level != last_raw[key])
                change_ms[key] = rd.now_ms;
            elapsed = rd.now_ms - change_ms[key];
            if (elapsed > {16'd0, debounce} && rd.raw_level != settled[key])
            begin
                settled[key]  = rd.raw_level;
                ev.press_fire = rd.raw_level;
            end
            last_raw[key]      = rd.raw_level;
            ev.pulse_key       = 4'(key);
            ev.debounced_level = settled[key];
        end
        expected_words.push_back(ev);
    endfunction

    // Compare one output word with the oldest prediction
    function void check_word(key_event_t got);
        key_event_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected output word, expected none, actual %h", $time, got);
            failures++;
            return;
        end
        want = expected_words.pop_front();
        if (got.press_fire)
            presses_seen++;
        if (got.press_fire !== want.press_fire)
        begin
            $display("%0t: press_fire expected %0b actual %0b", $time,
                     want.press_fire, got.press_fire);
            failures++;
        end
        if (got.pulse_key !== want.pulse_key)
        begin
            $display("%0t: pulse_key expected %0d actual %0d", $time,
                     want.pulse_key, got.pulse_key);
            failures++;
        end
        if (got.debounced_level !== want.debounced_level)
        begin
            $display("%0t: debounced_level expected %0b actual %0b", $time,
                     want.debounced_level, got.debounced_level);
            failures++;
        end
        if (got.pad !== 2'b00)
        begin
            $display("%0t: pad bits expected 0 actual %b", $time, got.pad);
            failures++;
        end
    endfunction
endclass

module key_matrix_debounce_top_tb;
    import kmd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [DEB_W-1:0]     cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    debounce_scoreboard   sb;
    bit                   tx_calm = 1'b0;
    bit                   rx_calm = 1'b0;
    logic [TIME_W-1:0]    scan_ms = '0;
    logic [DEB_W-1:0]     deb_now = DEBOUNCE_RESET;
    int                   readings_sent = 0;
    int                   settings_used = 1;
    int                   stall_cycles = 0;

    key_matrix_debounce_top #(
        .ROWS (4),
        .COLS (4)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receive output words and stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(key_event_t'(m_axis_tdata));
            if (rx_calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 7);
        end
    end

    // Abort when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d words still expected", $time,
                         sb.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one reading and hold it until the block takes it
    task automatic send_reading(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                                input logic raw, input logic [TIME_W-1:0] now);
        key_reading_t rd;
        int           gap;
        rd           = '0;
        rd.key_row   = row;
        rd.key_col   = col;
        rd.raw_level = raw;
        rd.now_ms    = now;
        gap          = 0;
        if (!tx_calm && $urandom_range(0, 99) < 7)
            gap = 1;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_reading(rd);
        readings_sent++;
    endtask

    // Hold off the sender until every predicted word has come back
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the debounce time; only called while the block is idle
    task automatic write_debounce(input logic [DEB_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_debounce(value);
        deb_now = value;
        settings_used++;
    endtask

    // Random key at a random or nearby time
    task automatic send_noise();
        logic [TIME_W-1:0] now;
        if ($urandom_range(0, 1) == 0)
            now = $urandom();
        else
            now = scan_ms + $urandom_range(0, 3);
        send_reading(ROW_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), now);
    endtask

    // Mostly bounce-then-hold sequences on one key, the rest noise
    task automatic run_sequences(input int count);
        int                done;
        int                bounces;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              lvl;
        logic [TIME_W-1:0] t0;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                row     = ROW_W'($urandom_range(0, 3));
                col     = COL_W'($urandom_range(0, 3));
                lvl     = 1'($urandom_range(0, 1));
                bounces = $urandom_range(0, 4);
                repeat (bounces)
                begin
                    scan_ms += $urandom_range(0, deb_now);
                    send_reading(row, col, 1'($urandom_range(0, 1)), scan_ms);
                    done++;
                end
                scan_ms += $urandom_range(1, 5);
                t0 = scan_ms;
                send_reading(row, col, lvl, t0);
                // occasionally break in with another reading
                if ($urandom_range(0, 4) == 0)
                begin
                    send_noise();
                    done++;
                end
                send_reading(row, col, lvl, t0 + deb_now);
                send_reading(row, col, lvl, t0 + deb_now + 1);
                if ($urandom_range(0, 2) == 0)
                begin
                    send_reading(row, col, lvl, t0 + deb_now + 1 + $urandom_range(0, 1000));
                    done++;
                end
                scan_ms = t0 + deb_now + 1;
                done += 3;
            end
            else
            begin
                send_noise();
                done++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset debounce time: change in same step, strict threshold, press and release
        send_reading(2'd0, 2'd0, 1'b0, 32'd0);
        send_reading(2'd0, 2'd0, 1'b1, 32'd10);
        send_reading(2'd0, 2'd0, 1'b1, 32'd60);
        send_reading(2'd0, 2'd0, 1'b1, 32'd61);
        send_reading(2'd0, 2'd0, 1'b1, 32'd200);
        // time wrap on the last key
        send_reading(2'd3, 2'd3, 1'b1, 32'hFFFF_FFF0);
        send_reading(2'd3, 2'd3, 1'b1, 32'h0000_0023);
        // bounce, then release accepted
        send_reading(2'd0, 2'd0, 1'b0, 32'd300);
        send_reading(2'd0, 2'd0, 1'b1, 32'd310);
        send_reading(2'd0, 2'd0, 1'b0, 32'd320);
        send_reading(2'd0, 2'd0, 1'b0, 32'd371);
        send_reading(2'd1, 2'd1, 1'b1, 32'hFFFF_FFFF);
        send_reading(2'd1, 2'd1, 1'b1, 32'd49);
        send_reading(2'd1, 2'd1, 1'b1, 32'd50);
        send_reading(2'd2, 2'd2, 1'b0, 32'hFFFF_FFFF);
        send_reading(2'd3, 2'd0, 1'b1, 32'h8000_0000);
        send_reading(2'd0, 2'd3, 1'b1, 32'h0000_0001);
        wait_results();

        // Zero debounce: accepted one ms after the change
        write_debounce(16'd0);
        send_reading(2'd1, 2'd2, 1'b1, 32'd1000);
        send_reading(2'd1, 2'd2, 1'b1, 32'd1000);
        send_reading(2'd1, 2'd2, 1'b1, 32'd1001);
        send_reading(2'd1, 2'd2, 1'b0, 32'd1001);
        send_reading(2'd1, 2'd2, 1'b0, 32'd1002);
        scan_ms = 32'd2000;
        run_sequences(120);
        wait_results();

        // Longest debounce, starting just before the time wrap
        write_debounce(16'hFFFF);
        scan_ms = 32'hFFFF_0000;
        run_sequences(120);
        wait_results();

        // Back to the default, both sides without idling
        write_debounce(16'd50);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_sequences(150);
        wait_results();
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Short random debounce, with a pause until the output drains mid-phase
        write_debounce(DEB_W'($urandom_range(1, 300)));
        run_sequences(75);
        wait_results();
        run_sequences(75);
        wait_results();

        write_debounce(DEB_W'($urandom_range(0, 65535)));
        scan_ms = $urandom();
        run_sequences(150);
        wait_results();

        write_debounce(16'd1);
        run_sequences(160);
        wait_results();

        $display("Run summary: %0d key readings over %0d debounce settings", readings_sent,
                 settings_used);
        $display("Run summary: %0d press pulses seen, %0d mismatches", sb.presses_seen,
                 sb.failures);
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
